// File: sv/ccst_pkg.sv
// Shared widths, types and coefficient program for the cubic curve square test.
`default_nettype none
package ccst_pkg;
    localparam int X_BITS_DEF = 41;
    localparam int N_W        = 12;
    localparam int W          = 128;
    localparam int MAG_W      = 42;
    localparam int MCH_W      = 21;
    localparam int SQ_W       = 84;
    localparam int S_W        = 87;
    localparam int SCH_W      = 29;
    localparam int PP_W       = MCH_W + SCH_W;
    localparam int PL_W       = PP_W + 2 * SCH_W;
    localparam int ROOT_W     = 64;
    localparam int PX_W       = 41;
    localparam int PY_W       = 62;
    localparam int N_OPS      = 12;
    localparam int OP_W       = 4;
    localparam int CNT_W      = 4;

    localparam logic [1:0] DEST_NONE = 2'd0;
    localparam logic [1:0] DEST_A6   = 2'd1;
    localparam logic [1:0] DEST_A4   = 2'd2;
    localparam logic [1:0] DEST_EXCL = 2'd3;

    typedef struct packed {
        logic [PX_W-1:0] x;
        logic            keep;
    } tag_t;

    typedef struct packed {
        logic signed [W-1:0] a4;
        logic signed [W-1:0] a6;
        logic signed [W-1:0] excl;
    } coef_t;

    function automatic logic op_start(input logic [OP_W-1:0] k);
        logic r;
        case (k)
            4'd0, 4'd6, 4'd10: r = 1'b1;
            default:           r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic signed [63:0] op_init(input logic [OP_W-1:0] k);
        logic signed [63:0] r;
        case (k)
            4'd0:    r = 64'sd117546246144;
            4'd6:    r = -64'sd45349632;
            4'd10:   r = -64'sd3888;
            default: r = 64'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [63:0] op_add(input logic [OP_W-1:0] k);
        logic signed [63:0] r;
        case (k)
            4'd0:    r = -64'sd1632586752;
            4'd1:    r = 64'sd3779136;
            4'd4:    r = -64'sd57;
            4'd6:    r = 64'sd419904;
            default: r = 64'sd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] op_dest(input logic [OP_W-1:0] k);
        logic [1:0] r;
        case (k)
            4'd5:    r = DEST_A6;
            4'd9:    r = DEST_A4;
            4'd11:   r = DEST_EXCL;
            default: r = DEST_NONE;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

// File: sv/ccst_coef.sv
// Serial Horner sequencer deriving curve coefficients from the family index.
`default_nettype none
module ccst_coef (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic signed [ccst_pkg::N_W-1:0] family_index,
    output logic                                 busy,
    output ccst_pkg::coef_t                      coef
);
    import ccst_pkg::*;

    logic signed [N_W-1:0] n_reg, n_next;
    logic [OP_W-1:0]       op_reg, op_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic signed [W-1:0]   acc_reg, acc_next;
    logic signed [W-1:0]   mcand_reg, mcand_next;
    logic signed [W-1:0]   prod_reg, prod_next;
    coef_t                 coef_reg, coef_next;
    logic [CNT_W-1:0]      bit_idx;
    logic signed [W-1:0]   sum;

    assign bit_idx = cnt_reg - CNT_W'(1);
    assign sum     = prod_reg + W'(op_add(op_reg));

    always_comb
    begin
        n_next     = n_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        prod_next  = prod_reg;
        coef_next  = coef_reg;
        if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                mcand_next = op_start(op_reg) ? W'(op_init(op_reg)) : acc_reg;
                prod_next  = '0;
                cnt_next   = cnt_reg + CNT_W'(1);
            end
            else if (cnt_reg <= CNT_W'(N_W))
            begin
                if (n_reg[bit_idx])
                begin
                    prod_next = (bit_idx == CNT_W'(N_W - 1)) ? prod_reg - mcand_reg
                                                             : prod_reg + mcand_reg;
                end
                mcand_next = mcand_reg <<< 1;
                cnt_next   = cnt_reg + CNT_W'(1);
            end
            else
            begin
                acc_next = sum;
                case (op_dest(op_reg))
                    DEST_A6:   coef_next.a6   = sum;
                    DEST_A4:   coef_next.a4   = sum;
                    DEST_EXCL: coef_next.excl = sum;
                    default:   coef_next      = coef_reg;
                endcase
                cnt_next = '0;
                if (op_reg == OP_W'(N_OPS - 1))
                    busy_next = 1'b0;
                else
                    op_next = op_reg + OP_W'(1);
            end
        end
        if (cfg_write)
        begin
            n_next    = family_index;
            busy_next = 1'b1;
            op_next   = '0;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg    <= N_W'(1);
            op_reg   <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
        end
        else
        begin
            n_reg    <= n_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        prod_reg  <= prod_next;
        coef_reg  <= coef_next;
    end

    assign busy = busy_reg;
    assign coef = coef_reg;
endmodule
`default_nettype wire

// File: sv/ccst_sqrt.sv
// Pipelined restoring integer square root, one result bit per stage.
`default_nettype none
module ccst_sqrt (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         adv,
    input  wire logic                         in_valid,
    input  wire logic [ccst_pkg::W-1:0]       in_rad,
    input  wire ccst_pkg::tag_t               in_tag,
    output logic                              out_valid,
    output logic [ccst_pkg::ROOT_W-1:0]       out_root,
    output logic                              out_rem_zero,
    output ccst_pkg::tag_t                    out_tag
);
    import ccst_pkg::*;

    logic [ROOT_W-1:0] vld_reg;
    logic [W-1:0]      rem_reg   [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    tag_t              tag_reg   [ROOT_W];
    logic [W-1:0]      rem_src   [ROOT_W];
    logic [ROOT_W-1:0] root_src  [ROOT_W];
    tag_t              tag_src   [ROOT_W];
    logic [W-1:0]      rem_next  [ROOT_W];
    logic [ROOT_W-1:0] root_next [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_stage
        localparam int B = ROOT_W - 1 - k;
        logic [W-1:0] trial;
        logic         fits;

        if (k == 0)
        begin : g_first
            assign rem_src[k]  = in_rad;
            assign root_src[k] = '0;
            assign tag_src[k]  = in_tag;
        end
        else
        begin : g_rest
            assign rem_src[k]  = rem_reg[k-1];
            assign root_src[k] = root_reg[k-1];
            assign tag_src[k]  = tag_reg[k-1];
        end

        assign trial        = (W'(root_src[k]) << (B + 1)) | (W'(1) << (2 * B));
        assign fits         = rem_src[k] >= trial;
        assign rem_next[k]  = fits ? rem_src[k] - trial : rem_src[k];
        assign root_next[k] = fits ? (root_src[k] | (ROOT_W'(1) << B)) : root_src[k];

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                tag_reg[k]  <= tag_src[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[ROOT_W-2:0], in_valid};
    end

    assign out_valid    = vld_reg[ROOT_W-1];
    assign out_root     = root_reg[ROOT_W-1];
    assign out_rem_zero = (rem_reg[ROOT_W-1] == '0);
    assign out_tag      = tag_reg[ROOT_W-1];
endmodule
`default_nettype wire

// File: sv/cubic_curve_square_test.sv
// Top level: tests candidate abscissas for integral points on a cubic curve family.
//
// Usage: load the family index n on the cfg channel (family_index, cfg_valid/cfg_ready)
// while no item is in flight. After reset or a write the block derives the curve
// coefficients serially, with in_ready held low. Then each candidate_x
// item on in_valid/in_ready is tested: a result (point_x, point_y, has_mirror) is
// offered on out_valid/out_ready only when X^3 + a4*X + a6 is a non-negative perfect
// square and X is not the excluded abscissa; other items vanish.
// Throughput: one item per cycle while no stall holds the pipeline. Each item passes
// 10 arithmetic stages for the cubic and 64 square root stages, one root bit each,
// before its result is loaded into the output register.
// Reset: family index returns to 1, all stages empty, coefficient run starts.
// Stall: a held result blocks the pipeline only when the next result reaches the
// end; items without a result and empty slots keep moving.
`default_nettype none
module cubic_curve_square_test #(
    parameter int X_BITS = ccst_pkg::X_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic signed [ccst_pkg::N_W-1:0]  family_index,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic signed [X_BITS-1:0]         candidate_x,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic signed [ccst_pkg::PX_W-1:0]      point_x,
    output logic [ccst_pkg::PY_W-1:0]             point_y,
    output logic                                  has_mirror
);
    import ccst_pkg::*;

    localparam int STAGES = 10;

    logic  busy;
    coef_t coef;
    logic  adv;
    logic  hit;

    logic [STAGES-1:0] vld_reg;
    tag_t              tag_reg [STAGES];
    tag_t              tag_next[STAGES];

    logic signed [MAG_W-1:0] xw;
    logic [MAG_W-1:0]        s1_m_reg, s1_m_next;
    logic                    s1_sx_reg;
    logic [MAG_W-1:0]        s2_ll_reg, s2_lh_reg, s2_hh_reg, s2_m_reg;
    logic                    s2_sx_reg;
    logic [SQ_W-1:0]         s3_sq_reg, s3_sq_next;
    logic [MAG_W-1:0]        s3_m_reg;
    logic                    s3_sx_reg;
    logic signed [S_W-1:0]   s4_s_reg, s4_s_next;
    logic [MAG_W-1:0]        s4_m_reg;
    logic                    s4_sx_reg;
    logic [S_W-1:0]          s5_ms_reg, s5_ms_next;
    logic [MAG_W-1:0]        s5_m_reg;
    logic                    s5_neg_reg;
    logic [PP_W-1:0]         s6_pp_reg [2][3];
    logic                    s6_neg_reg;
    logic [PL_W-1:0]         s7_pl_reg, s7_ph_reg, s7_pl_next, s7_ph_next;
    logic                    s7_neg_reg;
    logic [W-1:0]            s8_p_reg, s8_p_next;
    logic                    s8_neg_reg;
    logic signed [W-1:0]     s9_sp_reg, s9_sp_next;
    logic signed [W-1:0]     s10_rhs_reg, s10_rhs_next;

    tag_t              sq_in_tag;
    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    logic              sq_rem_zero;
    tag_t              sq_tag;

    logic                  out_valid_reg, out_valid_next;
    logic signed [PX_W-1:0] px_reg;
    logic [PY_W-1:0]       py_reg;
    logic                  mirror_reg;

    ccst_coef u_coef (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_valid && cfg_ready),
        .family_index (family_index),
        .busy         (busy),
        .coef         (coef)
    );

    assign cfg_ready = 1'b1;
    assign hit       = sq_valid && sq_tag.keep && sq_rem_zero;
    assign adv       = !(hit && out_valid_reg && !out_ready);
    assign in_ready  = adv && !busy;

    assign xw        = MAG_W'(candidate_x);
    assign s1_m_next = xw[MAG_W-1] ? MAG_W'(-xw) : MAG_W'(xw);

    assign s3_sq_next = (SQ_W'(s2_hh_reg) << (2 * MCH_W))
                      + (SQ_W'(s2_lh_reg) << (MCH_W + 1))
                      + SQ_W'(s2_ll_reg);
    assign s4_s_next  = signed'(S_W'(s3_sq_reg)) + S_W'(coef.a4);
    assign s5_ms_next = s4_s_reg[S_W-1] ? S_W'(-s4_s_reg) : S_W'(s4_s_reg);
    assign s7_pl_next = PL_W'(s6_pp_reg[0][0]) + (PL_W'(s6_pp_reg[0][1]) << SCH_W)
                      + (PL_W'(s6_pp_reg[0][2]) << (2 * SCH_W));
    assign s7_ph_next = PL_W'(s6_pp_reg[1][0]) + (PL_W'(s6_pp_reg[1][1]) << SCH_W)
                      + (PL_W'(s6_pp_reg[1][2]) << (2 * SCH_W));
    assign s8_p_next    = W'(s7_pl_reg) + (W'(s7_ph_reg) << MCH_W);
    assign s9_sp_next   = s8_neg_reg ? -signed'(s8_p_reg) : signed'(s8_p_reg);
    assign s10_rhs_next = s9_sp_reg + coef.a6;

    always_comb
    begin
        tag_next[0].x    = xw[PX_W-1:0];
        tag_next[0].keep = (W'(xw) != coef.excl);
        for (int k = 1; k < STAGES; k++)
            tag_next[k] = tag_reg[k-1];
    end

    assign sq_in_tag.x    = tag_reg[STAGES-1].x;
    assign sq_in_tag.keep = tag_reg[STAGES-1].keep && !s10_rhs_reg[W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[STAGES-2:0], in_valid && in_ready};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < STAGES; k++)
                tag_reg[k] <= tag_next[k];
            s1_m_reg   <= s1_m_next;
            s1_sx_reg  <= xw[MAG_W-1];
            s2_ll_reg  <= MAG_W'(s1_m_reg[MCH_W-1:0]) * MAG_W'(s1_m_reg[MCH_W-1:0]);
            s2_lh_reg  <= MAG_W'(s1_m_reg[MCH_W-1:0]) * MAG_W'(s1_m_reg[MAG_W-1:MCH_W]);
            s2_hh_reg  <= MAG_W'(s1_m_reg[MAG_W-1:MCH_W]) * MAG_W'(s1_m_reg[MAG_W-1:MCH_W]);
            s2_m_reg   <= s1_m_reg;
            s2_sx_reg  <= s1_sx_reg;
            s3_sq_reg  <= s3_sq_next;
            s3_m_reg   <= s2_m_reg;
            s3_sx_reg  <= s2_sx_reg;
            s4_s_reg   <= s4_s_next;
            s4_m_reg   <= s3_m_reg;
            s4_sx_reg  <= s3_sx_reg;
            s5_ms_reg  <= s5_ms_next;
            s5_m_reg   <= s4_m_reg;
            s5_neg_reg <= s4_s_reg[S_W-1] ^ s4_sx_reg;
            for (int i = 0; i < 2; i++)
                for (int j = 0; j < 3; j++)
                    s6_pp_reg[i][j] <= PP_W'(s5_m_reg[i*MCH_W +: MCH_W])
                                     * PP_W'(s5_ms_reg[j*SCH_W +: SCH_W]);
            s6_neg_reg  <= s5_neg_reg;
            s7_pl_reg   <= s7_pl_next;
            s7_ph_reg   <= s7_ph_next;
            s7_neg_reg  <= s6_neg_reg;
            s8_p_reg    <= s8_p_next;
            s8_neg_reg  <= s7_neg_reg;
            s9_sp_reg   <= s9_sp_next;
            s10_rhs_reg <= s10_rhs_next;
        end
    end

    ccst_sqrt u_sqrt (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .in_valid     (vld_reg[STAGES-1]),
        .in_rad       (s10_rhs_reg),
        .in_tag       (sq_in_tag),
        .out_valid    (sq_valid),
        .out_root     (sq_root),
        .out_rem_zero (sq_rem_zero),
        .out_tag      (sq_tag)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (adv && hit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv && hit)
        begin
            px_reg     <= signed'(sq_tag.x);
            py_reg     <= sq_root[PY_W-1:0];
            mirror_reg <= (sq_root != '0);
        end
    end

    assign out_valid  = out_valid_reg;
    assign point_x    = px_reg;
    assign point_y    = py_reg;
    assign has_mirror = mirror_reg;

    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !in_ready)
        else $error("item accepted while coefficients recompute");

    a_result_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(hit && adv))
        else $error("result appeared without a finished item");
endmodule
`default_nettype wire

// File: tb/sv/tb.sv
// Testbench for cubic_curve_square_test: predicts integral points and checks the result stream.
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import ccst_pkg::*;

    typedef logic signed [127:0] wide_t;
    typedef struct {
        logic [PX_W-1:0] x;
        logic [PY_W-1:0] y;
        logic            mirror;
    } point_t;

    class point_board;
        int     fam;
        point_t points[$];
        int     errors;

        function new();
            fam = 1;
            errors = 0;
        endfunction

        function automatic void root_of(input logic [127:0] v_in, output logic [127:0] root,
                                        output logic [127:0] rest);
            logic [127:0] v;
            logic [127:0] res;
            logic [127:0] b;
            v = v_in;
            res = '0;
            b = 128'd1 << 126;
            while (b > v && b != 0)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            root = res;
            rest = v;
        endfunction

        function automatic void note_candidate(input logic signed [40:0] x_in);
            wide_t n;
            wide_t x;
            wide_t n2;
            wide_t n3;
            wide_t n4;
            wide_t n5;
            wide_t n6;
            wide_t a4;
            wide_t a6;
            wide_t excl;
            wide_t cubic;
            logic [127:0] root;
            logic [127:0] rest;
            point_t p;
            n = 128'(fam);
            x = 128'(x_in);
            n2 = n * n;
            n3 = n2 * n;
            n4 = n3 * n;
            n5 = n4 * n;
            n6 = n5 * n;
            a4 = -128'sd45349632 * n4 + 128'sd419904 * n3;
            a6 = 128'sd3 * (128'sd39182082048 * n6 - 128'sd544195584 * n5
                 + 128'sd1259712 * n4 - 128'sd19 * n);
            excl = -128'sd3888 * n2;
            if (x == excl)
                return;
            cubic = x * x * x + a4 * x + a6;
            if (cubic < 0)
                return;
            root_of(cubic, root, rest);
            if (rest != 0)
                return;
            p.x = x_in;
            p.y = root[PY_W-1:0];
            p.mirror = (root != 0);
            points.push_back(p);
        endfunction

        task report(input string msg);
            $display("ERROR %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_point(input point_t got);
            point_t e;
            if (points.size() == 0)
            begin
                report($sformatf("unexpected point x=%0h y=%0h", got.x, got.y));
                return;
            end
            e = points.pop_front();
            if (got.x !== e.x)
                report($sformatf("point_x %0h, want %0h", got.x, e.x));
            if (got.y !== e.y)
                report($sformatf("point_y %0h, want %0h (x=%0h)", got.y, e.y, e.x));
            if (got.mirror !== e.mirror)
                report($sformatf("has_mirror %0b, want %0b (x=%0h)", got.mirror, e.mirror, e.x));
        endtask
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic signed [N_W-1:0]    family_index;
    logic                     in_valid;
    logic                     in_ready;
    logic signed [40:0]       candidate_x;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [PX_W-1:0]   point_x;
    logic [PY_W-1:0]          point_y;
    logic                     has_mirror;

    point_board board;
    int         tx_idle_pct;
    int         rx_idle_pct;
    int         hold_asks;
    int         hold_seen;
    int         hold_left;
    logic       taken;
    point_t     seen;

    cubic_curve_square_test #(.X_BITS(41)) uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .family_index(family_index),
        .in_valid(in_valid), .in_ready(in_ready), .candidate_x(candidate_x),
        .out_valid(out_valid), .out_ready(out_ready),
        .point_x(point_x), .point_y(point_y), .has_mirror(has_mirror)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #5_000_000;
        $display("cubic_curve_square_test: mismatch");
        $finish;
    end

    always @(negedge clk)
    begin
        taken <= out_valid && out_ready;
        seen.x <= point_x;
        seen.y <= point_y;
        seen.mirror <= has_mirror;
    end

    always @(posedge clk)
    begin
        if (rst_n && taken)
            board.check_point(seen);
        if (hold_asks != hold_seen)
        begin
            hold_seen = hold_asks;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task send_candidate(input logic signed [40:0] x);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        candidate_x <= x;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        board.note_candidate(x);
    endtask

    task drain;
        in_valid <= 1'b0;
        while (board.points.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task write_family(input logic signed [N_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        family_index <= v;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        board.fam = int'(v);
    endtask

    function automatic logic signed [40:0] pick_candidate(input int fam);
        logic signed [40:0] r;
        logic [19:0]        k;
        int                 sel;
        sel = $urandom_range(99);
        r = 41'({$urandom(), $urandom()});
        if (fam == 0 && sel < 85)
        begin
            k = (sel < 20) ? 20'($urandom_range(40)) : 20'($urandom_range(1048575));
            r = 41'(k) * 41'(k);
        end
        else if (sel < 30)
            r = 41'($signed($urandom_range(2000)) - 1000);
        else if (sel < 40)
            r = 41'(-64'sd3888 * 64'(fam) * 64'(fam));
        return r;
    endfunction

    initial
    begin
        int fams[14];
        int total;
        logic signed [40:0] directed_one[8];
        logic signed [40:0] directed_zero[7];
        board = new();
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        family_index = '0;
        in_valid = 1'b0;
        candidate_x = '0;
        out_ready = 1'b0;
        taken = 1'b0;
        hold_asks = 0;
        hold_seen = 0;
        hold_left = 0;
        tx_idle_pct = 20;
        rx_idle_pct = 64;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        directed_one = '{41'sd0, 41'sd1, -41'sd1, 41'sh0FFFFFFFFFF, -41'sh10000000000,
                         -41'sd3888, 41'sd3888, 41'sh15555555555};
        foreach (directed_one[i])
            send_candidate(directed_one[i]);
        write_family(N_W'(0));
        directed_zero = '{41'sd0, 41'sd1, 41'sd4, -41'sd1, 41'sd1099509530625,
                          41'sh0AAAAAAAAAA, 41'sh0FFFFFFFFFF};
        foreach (directed_zero[i])
            send_candidate(directed_zero[i]);

        fams = '{0, -2048, 0, 2047, -1024, 0, 1024, 0, -1, 0, 0, 5, 0, 0};
        fams[7] = $signed($urandom_range(4095)) - 2048;
        total = 0;
        foreach (fams[p])
        begin
            write_family(N_W'(fams[p]));
            if (p == 2 || p == 12)
                hold_asks++;
            repeat (75)
            begin
                if (total == 350)
                begin
                    tx_idle_pct = 64;
                    rx_idle_pct = 20;
                end
                else if (total == 700)
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
                send_candidate(pick_candidate(fams[p]));
                total++;
            end
        end
        write_family(N_W'(1));
        repeat (20)
            send_candidate(pick_candidate(1));
        drain();

        if (board.errors == 0 && board.points.size() == 0)
            $display("cubic_curve_square_test: match");
        else
            $display("cubic_curve_square_test: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
